// ===== hw/rtl/coat_pkg.sv =====
// ----------------------------------------------------------------------------
// coat_pkg: shared types and constants for the CO exposure alarm timer
// Holds the band thresholds, register indexes, reset values of the limit
// registers and the codes carried on the result channel.
// ----------------------------------------------------------------------------
package coat_pkg;

   // Field widths fixed by the interface.
   localparam int PpmWidth   = 10;
   localparam int LimitWidth = 16;
   localparam int TimeWidth  = 16;
   localparam int CsrWidth   = 16;
   localparam int CsrIdxWidth = 3;

   // Default timer width.
   localparam int CountWidthDefault = 16;

   // Band thresholds in whole ppm; a reading equal to the threshold is in band.
   localparam logic [PpmWidth-1:0] Band30Ppm  = 10'd30;
   localparam logic [PpmWidth-1:0] Band50Ppm  = 10'd50;
   localparam logic [PpmWidth-1:0] Band100Ppm = 10'd100;
   localparam logic [PpmWidth-1:0] Band300Ppm = 10'd300;

   // Reset values of the limit registers, in seconds.
   localparam logic [LimitWidth-1:0] Limit30Reset  = 16'd20;
   localparam logic [LimitWidth-1:0] Limit50Reset  = 16'd3600;
   localparam logic [LimitWidth-1:0] Limit100Reset = 16'd600;
   localparam logic [LimitWidth-1:0] Limit300Reset = 16'd600;

   // Configuration register indexes.
   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_ARMED         = 3'd0,
      CSR_LIMIT_BAND30  = 3'd1,
      CSR_LIMIT_BAND50  = 3'd2,
      CSR_LIMIT_BAND100 = 3'd3,
      CSR_LIMIT_BAND300 = 3'd4
   } csr_index_type;

   // Band that raised the alarm.
   typedef enum logic [2:0] {
      SRC_NONE    = 3'd0,
      SRC_BAND30  = 3'd1,
      SRC_BAND50  = 3'd2,
      SRC_BAND100 = 3'd3,
      SRC_BAND300 = 3'd4
   } source_type;

   // Command for the buzzer.
   typedef enum logic [1:0] {
      BEEP_STOP  = 2'd0,
      BEEP_SHORT = 2'd1,
      BEEP_LONG  = 2'd2,
      BEEP_NONE  = 2'd3
   } beep_type;

endpackage

// ===== hw/rtl/co_exposure_alarm_timer.sv =====
// ----------------------------------------------------------------------------
// co_exposure_alarm_timer: carbon monoxide exposure alarm timer
// Four band timers with prioritized limit checks, one result per reading.
// ----------------------------------------------------------------------------
// Usage:
// One beat on the req channel carries one CO reading in whole ppm, one per
// one-second tick. Each accepted reading gives exactly one beat on the rsp
// channel: the alarm flag, the band that raised it, a beep command and the
// four timer values after that tick.
// A reading is registered at acceptance and then evaluated into the output
// register, which drives rsp_valid. Throughput is one reading per cycle
// while rsp_stall is low; the limit is the update of the timer registers,
// done once per beat.
// The input register keeps taking readings while a result waits, as long as
// the result register can drain; with rsp_stall high and both stages full,
// req_stall rises and the pipeline holds without loss.
// Reset clears both stages, the timers and the alarm flag, disarms the block
// and loads the default limits (20, 3600, 600 and 600 seconds). The user must
// write configuration through csr_write_en only while idle; not enforced.
// ----------------------------------------------------------------------------
module co_exposure_alarm_timer
   import coat_pkg::*;
#(
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic                    clock,
   input  logic                    reset,
   // Configuration port.
   input  logic                    csr_write_en,
   input  logic [CsrIdxWidth-1:0]  csr_index,
   input  logic [CsrWidth-1:0]     csr_wdata,
   // Reading channel.
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [PpmWidth-1:0]     req_co_ppm,
   // Result channel.
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic                    rsp_alarm_on,
   output logic [2:0]              rsp_alarm_source,
   output logic [1:0]              rsp_beep_command,
   output logic [TimeWidth-1:0]    rsp_time_band30,
   output logic [TimeWidth-1:0]    rsp_time_band50,
   output logic [TimeWidth-1:0]    rsp_time_band100,
   output logic [TimeWidth-1:0]    rsp_time_band300
);

   localparam int NumBands = 4;
   localparam int ExtWidth = (COUNT_WIDTH > TimeWidth) ? COUNT_WIDTH : TimeWidth;

   // Configuration registers.
   logic                  armed_ff;
   logic [LimitWidth-1:0] limit30_ff;
   logic [LimitWidth-1:0] limit50_ff;
   logic [LimitWidth-1:0] limit100_ff;
   logic [LimitWidth-1:0] limit300_ff;

   // Pipeline registers.
   logic                  in_valid_ff;
   logic [PpmWidth-1:0]   ppm_ff;
   logic                  out_valid_ff;
   logic                  alarm_ff;
   logic                  alarm_in;
   source_type            source_ff;
   source_type            source_in;
   beep_type              beep_ff;
   beep_type              beep_in;

   logic                  out_free;
   logic                  step;
   logic [NumBands-1:0]   in_band;
   logic [NumBands-1:0]   over;
   logic [COUNT_WIDTH-1:0] count30;
   logic [COUNT_WIDTH-1:0] count50;
   logic [COUNT_WIDTH-1:0] count100;
   logic [COUNT_WIDTH-1:0] count300;

   // Configuration writes; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         armed_ff    <= 1'b0;
         limit30_ff  <= Limit30Reset;
         limit50_ff  <= Limit50Reset;
         limit100_ff <= Limit100Reset;
         limit300_ff <= Limit300Reset;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_ARMED:         armed_ff    <= csr_wdata[0];
            CSR_LIMIT_BAND30:  limit30_ff  <= csr_wdata;
            CSR_LIMIT_BAND50:  limit50_ff  <= csr_wdata;
            CSR_LIMIT_BAND100: limit100_ff <= csr_wdata;
            CSR_LIMIT_BAND300: limit300_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Handshake: the result register frees when empty or being taken.
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         ppm_ff <= req_co_ppm;
      end
   end

   // Band membership of the registered reading.
   assign in_band[0] = ppm_ff >= Band30Ppm;
   assign in_band[1] = ppm_ff >= Band50Ppm;
   assign in_band[2] = ppm_ff >= Band100Ppm;
   assign in_band[3] = ppm_ff >= Band300Ppm;

   // The four exposure timers; their registers also serve as result fields.
   coat_band_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_timer30 (
      .clock(clock), .reset(reset), .step(step), .in_band(in_band[0]),
      .limit(limit30_ff), .count(count30), .over(over[0]));

   coat_band_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_timer50 (
      .clock(clock), .reset(reset), .step(step), .in_band(in_band[1]),
      .limit(limit50_ff), .count(count50), .over(over[1]));

   coat_band_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_timer100 (
      .clock(clock), .reset(reset), .step(step), .in_band(in_band[2]),
      .limit(limit100_ff), .count(count100), .over(over[2]));

   coat_band_timer #(.COUNT_WIDTH(COUNT_WIDTH)) u_timer300 (
      .clock(clock), .reset(reset), .step(step), .in_band(in_band[3]),
      .limit(limit300_ff), .count(count300), .over(over[3]));

   // Priority check of the timers; disarmed keeps the flag and sends no command.
   always_comb begin
      alarm_in  = alarm_ff;
      source_in = SRC_NONE;
      beep_in   = BEEP_NONE;
      if (armed_ff) begin
         if (over[0]) begin
            source_in = SRC_BAND30;
            beep_in   = BEEP_SHORT;
         end else if (over[1]) begin
            source_in = SRC_BAND50;
            beep_in   = BEEP_LONG;
         end else if (over[2]) begin
            source_in = SRC_BAND100;
            beep_in   = BEEP_LONG;
         end else if (over[3]) begin
            source_in = SRC_BAND300;
            beep_in   = BEEP_LONG;
         end else begin
            source_in = SRC_NONE;
            beep_in   = BEEP_STOP;
         end
         alarm_in = |over;
      end
   end

   // Result register and stored alarm flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         alarm_ff     <= 1'b0;
      end else begin
         if (out_free) begin
            out_valid_ff <= in_valid_ff;
         end
         if (step) begin
            alarm_ff <= alarm_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         source_ff <= source_in;
         beep_ff   <= beep_in;
      end
   end

   // Result fields; the timers show their low bits.
   assign rsp_valid        = out_valid_ff;
   assign rsp_alarm_on     = alarm_ff;
   assign rsp_alarm_source = source_ff;
   assign rsp_beep_command = beep_ff;
   assign rsp_time_band30  = TimeWidth'(ExtWidth'(count30));
   assign rsp_time_band50  = TimeWidth'(ExtWidth'(count50));
   assign rsp_time_band100 = TimeWidth'(ExtWidth'(count100));
   assign rsp_time_band300 = TimeWidth'(ExtWidth'(count300));

endmodule

// ===== hw/rtl/coat_band_timer.sv =====
// ----------------------------------------------------------------------------
// coat_band_timer: one saturating exposure timer
// Counts ticks while the reading is in band, clears otherwise, and flags
// when the updated count is strictly above its limit.
// ----------------------------------------------------------------------------
module coat_band_timer
   import coat_pkg::*;
#(
   parameter int COUNT_WIDTH = CountWidthDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic                   in_band,
   input  logic [LimitWidth-1:0]  limit,
   output logic [COUNT_WIDTH-1:0] count,
   output logic                   over
);

   // Compare at whichever is wider: the counter or the limit.
   localparam int CmpWidth = (COUNT_WIDTH > LimitWidth) ? COUNT_WIDTH : LimitWidth;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;

   // Next count: clear out of band, saturate at all ones.
   always_comb begin
      if (!in_band) begin
         count_in = '0;
      end else if (count_ff == {COUNT_WIDTH{1'b1}}) begin
         count_in = count_ff;
      end else begin
         count_in = count_ff + COUNT_WIDTH'(1);
      end
   end

   // The limit check looks at the count after this tick.
   assign over = CmpWidth'(count_in) > CmpWidth'(limit);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (step) begin
         count_ff <= count_in;
      end
   end

   assign count = count_ff;

endmodule
